// ----- hdl/chm_pkg.sv -----
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map
// Request kinds, cell operations, the control word broadcast to the cell
// row, and the default size of the entry pool.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int KIND_W          = 2;
    localparam int KEY_W           = 32;
    localparam int VALUE_W         = 32;
    localparam int ENTRY_COUNT_DEF = 256;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_GET    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK
    } t_state;

    // What every cell of the row does under the broadcast control word.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_SHIFT,
        CELL_LOAD,
        CELL_UPDATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_cell_ctl;

endpackage

// ----- hdl/chm_cell.sv -----
// ----------------------------------------------------------------------------
// chm_cell: one entry of the map
// Holds one key and its value. The occupied cells form a ring that starts
// at cell 0; on a rotate each cell takes its right neighbor and the last
// occupied cell takes the head. A shift drops the head.
// ----------------------------------------------------------------------------
module chm_cell
    import chm_pkg::*;
#(
    parameter int CNT_W      = 9,
    parameter int CELL_INDEX = 0
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [CNT_W-1:0]   i_count,
    input  logic [KEY_W-1:0]   i_next_key,
    input  logic [VALUE_W-1:0] i_next_value,
    input  logic [KEY_W-1:0]   i_head_key,
    input  logic [VALUE_W-1:0] i_head_value,
    output logic [KEY_W-1:0]   o_key,
    output logic [VALUE_W-1:0] o_value
);

    // This cell is the tail of the ring when count equals its index plus one,
    // and the first free cell when count equals its index.
    localparam logic [CNT_W-1:0] TAIL_POS = CNT_W'(CELL_INDEX + 1);
    localparam logic [CNT_W-1:0] FREE_POS = CNT_W'(CELL_INDEX);
    localparam bit               IS_HEAD  = (CELL_INDEX == 0);

    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   n_key;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        unique case (i_ctl.op)
            CELL_HOLD: begin
            end
            CELL_ROTATE: begin
                if (i_count == TAIL_POS) begin
                    n_key   = i_head_key;
                    n_value = i_head_value;
                end else begin
                    n_key   = i_next_key;
                    n_value = i_next_value;
                end
            end
            CELL_SHIFT: begin
                n_key   = i_next_key;
                n_value = i_next_value;
            end
            CELL_LOAD: begin
                if (i_count == FREE_POS) begin
                    n_key   = i_ctl.key;
                    n_value = i_ctl.value;
                end
            end
            CELL_UPDATE: begin
                if (IS_HEAD) begin
                    n_value = i_ctl.value;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

// ----- hdl/chm_ctrl.sv -----
// ----------------------------------------------------------------------------
// chm_ctrl: request sequencer of the chained hash map
// Takes one request word, compares it against the head of the ring once a
// cycle while the ring rotates, then updates, loads or drops an entry as its
// kind requires and registers the result word.
// ----------------------------------------------------------------------------
module chm_ctrl
    import chm_pkg::*;
#(
    parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
    parameter int CNT_W       = $clog2(ENTRY_COUNT + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [KEY_W-1:0]   i_lookup_key,
    input  logic [VALUE_W-1:0] i_new_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic [VALUE_W-1:0] o_found_value,
    output logic               o_refused,
    input  logic [KEY_W-1:0]   i_head_key,
    input  logic [VALUE_W-1:0] i_head_value,
    output t_cell_ctl          o_ctl,
    output logic [CNT_W-1:0]   o_count
);

    localparam int                STEP_W = $clog2(ENTRY_COUNT);
    localparam logic [CNT_W-1:0] FULL   = CNT_W'(ENTRY_COUNT);
    localparam logic [CNT_W-1:0] ONE    = CNT_W'(1);

    t_state             r_state;
    t_state             n_state;
    t_kind              r_kind;
    t_kind              n_kind;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   n_key;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  n_step;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_hit;
    logic               n_hit;
    logic [VALUE_W-1:0] r_found;
    logic [VALUE_W-1:0] n_found;
    logic               r_refused;
    logic               n_refused;

    logic               w_empty;
    logic               w_match;
    logic               w_last;
    logic               w_full;
    logic               w_out_free;
    logic               w_fin;
    logic               w_fin_hit;
    logic [VALUE_W-1:0] w_fin_found;
    logic               w_fin_refused;
    t_cell_op           w_fin_op;
    logic [CNT_W-1:0]   w_fin_count;

    assign w_empty    = (r_count == '0);
    assign w_match    = !w_empty && (i_head_key == r_key);
    assign w_last     = w_empty || ((CNT_W'(r_step) + ONE) == r_count);
    assign w_full     = (r_count == FULL);
    assign w_out_free = !r_out_valid || !i_stall;

    // Outcome of the current head compare.
    always_comb begin
        w_fin         = 1'b0;
        w_fin_hit     = 1'b0;
        w_fin_found   = '0;
        w_fin_refused = 1'b0;
        w_fin_op      = CELL_HOLD;
        w_fin_count   = r_count;
        if (r_kind == KIND_NONE) begin
            w_fin = 1'b1;
        end else if (w_match) begin
            w_fin       = 1'b1;
            w_fin_hit   = 1'b1;
            w_fin_found = i_head_value;
            unique case (r_kind)
                KIND_INSERT: w_fin_op = CELL_UPDATE;
                KIND_REMOVE: begin
                    w_fin_op    = CELL_SHIFT;
                    w_fin_count = r_count - ONE;
                end
                default: w_fin_op = CELL_HOLD;
            endcase
        end else if (w_last) begin
            w_fin = 1'b1;
            if (r_kind == KIND_INSERT) begin
                if (w_full) begin
                    w_fin_refused = 1'b1;
                end else begin
                    w_fin_op    = CELL_LOAD;
                    w_fin_count = r_count + ONE;
                end
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_key       = r_key;
        n_value     = r_value;
        n_count     = r_count;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_hit       = r_hit;
        n_found     = r_found;
        n_refused   = r_refused;
        o_ctl.op    = CELL_HOLD;
        o_ctl.key   = r_key;
        o_ctl.value = r_value;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind  = t_kind'(i_kind);
                    n_key   = i_lookup_key;
                    n_value = i_new_value;
                    n_step  = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_fin) begin
                    // Hold the request until the result register frees up.
                    if (w_out_free) begin
                        o_ctl.op    = w_fin_op;
                        n_count     = w_fin_count;
                        n_out_valid = 1'b1;
                        n_hit       = w_fin_hit;
                        n_found     = w_fin_found;
                        n_refused   = w_fin_refused;
                        n_state     = S_IDLE;
                    end
                end else begin
                    o_ctl.op = CELL_ROTATE;
                    n_step   = r_step + STEP_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_value   <= n_value;
        r_step    <= n_step;
        r_hit     <= n_hit;
        r_found   <= n_found;
        r_refused <= n_refused;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_hit         = r_hit;
    assign o_found_value = r_found;
    assign o_refused     = r_refused;
    assign o_count       = r_count;

endmodule

// ----- hdl/chained_hash_map.sv -----
// ----------------------------------------------------------------------------
// chained_hash_map: key to value map over a fixed pool of entries
// Row of entry cells driven by a request sequencer.
// ----------------------------------------------------------------------------
// Each request word (insert or update, get, remove) gives one result word.
// The occupied entries sit packed in cells 0 to count-1 and form a ring that
// rotates one entry per cycle past a single key comparator at cell 0: a
// request is taken, then compared with one entry after another until a hit
// or until every entry has been examined; an unused kind compares none. A
// result that is not taken holds the next request at its final step. The
// entry a key lands in is not visible at the ports; an insert into a full
// pool is refused.
// ----------------------------------------------------------------------------
module chained_hash_map
    import chm_pkg::*;
#(
    parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [KEY_W-1:0]   i_lookup_key,
    input  logic [VALUE_W-1:0] i_new_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic [VALUE_W-1:0] o_found_value,
    output logic               o_refused
);

    localparam int CNT_W = $clog2(ENTRY_COUNT + 1);

    t_cell_ctl          w_ctl;
    logic [CNT_W-1:0]   w_count;
    logic [KEY_W-1:0]   w_key   [ENTRY_COUNT];
    logic [VALUE_W-1:0] w_value [ENTRY_COUNT];

    chm_ctrl #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_lookup_key  (i_lookup_key),
        .i_new_value   (i_new_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_found_value (o_found_value),
        .o_refused     (o_refused),
        .i_head_key    (w_key[0]),
        .i_head_value  (w_value[0]),
        .o_ctl         (w_ctl),
        .o_count       (w_count)
    );

    for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
        // The last cell has no right neighbor: feed back its own entry.
        localparam int NEXT = (g == ENTRY_COUNT - 1) ? g : g + 1;

        chm_cell #(
            .CNT_W      (CNT_W),
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (w_count),
            .i_next_key   (w_key[NEXT]),
            .i_next_value (w_value[NEXT]),
            .i_head_key   (w_key[0]),
            .i_head_value (w_value[0]),
            .o_key        (w_key[g]),
            .o_value      (w_value[g])
        );
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the chained hash map
// Drives insert, get and remove words over the valid/stall handshake with
// random idles on both sides. A directed table covers the empty map, the
// key and value extremes and the removal of entries; random traffic then runs
// over a small key pool, fills the pool to refusal and drains it again.
// Each result word is checked against its row's typed answer or a map predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import chm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SIZE    = ENTRY_COUNT_DEF;
    localparam int QUIET_LIMIT  = 4000;
    // a miss walks every entry
    localparam int SETTLE_WAIT  = 2 * POOL_SIZE + 16;
    localparam int KEY_POOL_LEN = 40;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] found_value;
        logic               refused;
    } t_answer;

    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               typed;
        t_answer            answer;
    } t_row;

    localparam int ROW_COUNT = 21;
    localparam t_row DIRECTED_ROWS [ROW_COUNT] = '{
        '{KIND_GET,    32'h0000_0000, 32'h1111_1111, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{KIND_REMOVE, 32'hFFFF_FFFF, 32'h0,         1'b1, '{1'b0, 32'h0, 1'b0}},
        '{KIND_NONE,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{KIND_GET,    32'h0000_0000, 32'h0,         1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0}},
        '{KIND_GET,    32'hFFFF_FFFF, 32'h0,         1'b1, '{1'b1, 32'h0, 1'b0}},
        '{KIND_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0}},
        // keys 0, 40h and 80h all present, then remove the middle one
        '{KIND_INSERT, 32'h0000_0040, 32'hA5A5_A5A5, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{KIND_INSERT, 32'h0000_0080, 32'h5A5A_5A5A, 1'b1, '{1'b0, 32'h0, 1'b0}},
        '{KIND_REMOVE, 32'h0000_0040, 32'h0,         1'b1,
          '{1'b1, 32'hA5A5_A5A5, 1'b0}},
        '{KIND_GET,    32'h0000_0040, 32'h0,         1'b1, '{1'b0, 32'h0, 1'b0}},
        '{KIND_GET,    32'h0000_0080, 32'h0,         1'b0, '0},
        '{KIND_REMOVE, 32'h0000_0000, 32'h0,         1'b1,
          '{1'b1, 32'h1234_5678, 1'b0}},
        '{KIND_GET,    32'h0000_0080, 32'h0,         1'b0, '0},
        '{KIND_NONE,   32'h0000_0080, 32'h0,         1'b1, '{1'b0, 32'h0, 1'b0}},
        '{KIND_INSERT, 32'h8000_0080, 32'hDEAD_BEEF, 1'b0, '0},
        '{KIND_REMOVE, 32'h0000_0080, 32'h0,         1'b1,
          '{1'b1, 32'h5A5A_5A5A, 1'b0}},
        '{KIND_REMOVE, 32'h0000_0080, 32'h0,         1'b1, '{1'b0, 32'h0, 1'b0}},
        '{KIND_REMOVE, 32'hFFFF_FFFF, 32'h0,         1'b1, '{1'b1, 32'h0, 1'b0}},
        '{KIND_GET,    32'h8000_0080, 32'h0,         1'b0, '0}
    };

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic [KIND_W-1:0]  i_kind       = '0;
    logic [KEY_W-1:0]   i_lookup_key = '0;
    logic [VALUE_W-1:0] i_new_value  = '0;
    logic               i_stall      = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic               o_hit;
    logic [VALUE_W-1:0] o_found_value;
    logic               o_refused;

    logic [VALUE_W-1:0] map_contents [logic [KEY_W-1:0]];
    t_answer            pending_answers [$];
    logic [KEY_W-1:0]   key_pool [KEY_POOL_LEN];

    int  words_sent    = 0;
    int  results_seen  = 0;
    int  hits_seen     = 0;
    int  refusals_seen = 0;
    int  mismatches    = 0;
    int  quiet_cycles  = 0;
    int  stall_left    = 0;
    bit  calm_stretch  = 1'b0;

    chained_hash_map #(
        .ENTRY_COUNT(POOL_SIZE)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_lookup_key (i_lookup_key),
        .i_new_value  (i_new_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hit        (o_hit),
        .o_found_value(o_found_value),
        .o_refused    (o_refused)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm_stretch || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Map semantics: one result per word; gets, unused kinds and missed removes leave the map as it is.
    function automatic t_answer apply_to_map(t_kind kind, logic [KEY_W-1:0] key,
                                             logic [VALUE_W-1:0] value);
        t_answer ans = '0;
        if (kind == KIND_NONE) return ans;
        if (map_contents.exists(key)) begin
            ans.hit         = 1'b1;
            ans.found_value = map_contents[key];
            if (kind == KIND_INSERT) map_contents[key] = value;
            else if (kind == KIND_REMOVE) map_contents.delete(key);
        end else if (kind == KIND_INSERT) begin
            if (map_contents.num() < POOL_SIZE) map_contents[key] = value;
            else ans.refused = 1'b1;
        end
        return ans;
    endfunction

    task automatic send_word(t_kind kind, logic [KEY_W-1:0] key,
                             logic [VALUE_W-1:0] value, bit typed, t_answer typed_answer);
        int      gap;
        t_answer predicted;
        if (words_sent % 64 == 0) calm_stretch = ($urandom_range(0, 3) == 0);
        gap = pick_idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_lookup_key <= key;
        i_new_value  <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = apply_to_map(kind, key, value);
        pending_answers.push_back(typed ? typed_answer : predicted);
        words_sent++;
    endtask

    task automatic send_random(t_kind kind, logic [KEY_W-1:0] key);
        send_word(kind, key, $urandom, 1'b0, '0);
    endtask

    task automatic wait_drained();
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return KIND_INSERT;
        if (r < 70) return KIND_GET;
        if (r < 95) return KIND_REMOVE;
        return KIND_NONE;
    endfunction

    // Churn over a small key pool so that hits, misses and updates all occur.
    task automatic churn_small_pool(int count);
        logic [KEY_W-1:0] base;
        base = $urandom;
        for (int i = 0; i < KEY_POOL_LEN; i++) begin
            if (i < 8) key_pool[i] = base + 32'(64 * i);
            else key_pool[i] = $urandom;
        end
        key_pool[8] = '0;
        key_pool[9] = '1;
        repeat (count) begin
            if ($urandom_range(0, 99) < 85)
                send_random(pick_kind(), key_pool[$urandom_range(0, KEY_POOL_LEN - 1)]);
            else
                send_random(pick_kind(), $urandom);
        end
    endtask

    // Result side: random stall, compare each accepted word with the oldest answer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                $error("result word with no request outstanding");
                mismatches++;
            end else begin
                t_answer want;
                want = pending_answers.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    mismatches++;
                end
                if (o_found_value !== want.found_value) begin
                    $error("found_value: expected %08h, got %08h",
                           want.found_value, o_found_value);
                    mismatches++;
                end
                if (o_refused !== want.refused) begin
                    $error("refused: expected %0d, got %0d", want.refused, o_refused);
                    mismatches++;
                end
                results_seen++;
                if (want.hit) hits_seen++;
                if (want.refused) refusals_seen++;
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            stall_left = pick_idle_len();
            i_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] fill_keys [$];
        logic [KEY_W-1:0] fresh;
        int               r;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_word(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].value,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].answer);
        i_valid <= 1'b0;
        wait_drained();

        churn_small_pool(220);

        // fill the pool to capacity, reading back keys along the way
        while (map_contents.num() < POOL_SIZE) begin
            if ($urandom_range(0, 3) == 0 && fill_keys.size() != 0) begin
                send_random(KIND_GET, fill_keys[$urandom_range(0, fill_keys.size() - 1)]);
            end else begin
                fresh = $urandom;
                fill_keys.push_back(fresh);
                send_random(KIND_INSERT, fresh);
            end
        end
        i_valid <= 1'b0;
        wait_drained();

        // full pool: new keys are refused, present keys still update, a remove frees room for a new key
        repeat (40) begin
            r = $urandom_range(0, 4);
            case (r)
                0: send_random(KIND_INSERT, $urandom);
                1: send_random(KIND_INSERT, fill_keys[$urandom_range(0, fill_keys.size() - 1)]);
                2: send_random(KIND_GET, fill_keys[$urandom_range(0, fill_keys.size() - 1)]);
                default: begin
                    send_random(KIND_REMOVE,
                                fill_keys[$urandom_range(0, fill_keys.size() - 1)]);
                    fresh = $urandom;
                    fill_keys.push_back(fresh);
                    send_random(KIND_INSERT, fresh);
                    send_random(KIND_INSERT, $urandom);
                end
            endcase
        end

        fill_keys.shuffle();
        foreach (fill_keys[i]) send_random(KIND_REMOVE, fill_keys[i]);

        churn_small_pool(80);
        i_valid <= 1'b0;

        wait_drained();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("%0d request words sent, %0d results checked", words_sent, results_seen);
        $display("%0d hits, %0d refused inserts, pool filled to %0d entries",
                 hits_seen, refusals_seen, POOL_SIZE);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- chained_hash_map.f -----
hdl/chm_pkg.sv
hdl/chm_cell.sv
hdl/chm_ctrl.sv
hdl/chained_hash_map.sv
tb/tb_top.sv
